// ===== src/u8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module of the block.
package u8d_pkg;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_BAD_ENC  = 2'd1,
    ST_BAD_CHAR = 2'd2
  } status_t;

  // One decoded result.
  typedef struct packed {
    status_t     status;
    logic [20:0] code_point;
    logic [7:0]  bytes_used;
  } result_t;

  // Everything one input byte produces: an optional result for the sequence it
  // closes (a) and an optional result of its own or a flush (b), in that order.
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } record_t;

  // Queue between front and back; depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: front end, record queue, back end.
// Depends on u8d_pkg, u8d_front, u8d_queue, u8d_back.
//
// Takes one byte per request on the input channel (data_byte with
// end_of_buffer on the last byte of a buffer) and gives one result per
// decoded sequence on the output channel: status (0 valid, 1 invalid
// encoding, 2 invalid character), code_point, bytes_used (saturating at 255)
// and run_final, set on the last result caused by a given input byte. A byte
// gives zero, one or two results; two when it closes an earlier sequence and
// also yields a result itself (ASCII byte, or end_of_buffer flush). Input
// bytes are accepted one per cycle while the output keeps up; a byte with
// two results sends them one after the other, and results leave at one per
// cycle while out_stall is low, set by the single registered output stage.
// The front end decodes each byte in the cycle it is accepted and, if it
// yields a result, writes a record into a two-entry queue; the back end
// drains that queue, so a stalled output does not stall the input until the
// queue fills. Both channels: a request moves when valid is high and stall
// is low. No configuration; sync active-high reset.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [20:0] code_point,
  output logic [7:0]  bytes_used,
  output logic        run_final
);
  import u8d_pkg::*;

  logic    push;
  logic    pop;
  logic    queue_full;
  logic    queue_empty;
  record_t push_rec;
  record_t head_rec;

  // byte classification and sequence state
  u8d_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .push          (push),
    .push_rec      (push_rec),
    .queue_full    (queue_full)
  );

  // decouples byte intake from result delivery
  u8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (queue_full),
    .pop      (pop),
    .head_rec (head_rec),
    .empty    (queue_empty)
  );

  // serializes up to two results per record onto the output
  u8d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_rec   (head_rec),
    .empty      (queue_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .code_point (code_point),
    .bytes_used (bytes_used),
    .run_final  (run_final)
  );

endmodule

// ===== src/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds one record
// per byte with the results it causes. Depends on u8d_pkg.
module u8d_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             end_of_buffer,
  output logic             push,
  output u8d_pkg::record_t push_rec,
  input  logic             queue_full
);
  import u8d_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SKIP    = 2'd2
  } mode_t;

  mode_t       mode, mode_next;
  logic [20:0] acc, acc_next;
  logic [2:0]  exp_len, exp_len_next;
  logic [7:0]  seen, seen_next;

  logic        accept;
  logic        is_cont;
  logic        taken;
  logic [7:0]  seen_inc;
  logic [20:0] acc_shift;
  record_t     rec;

  function automatic result_t bad_enc(input logic [7:0] used);
    result_t r;
    r.status     = ST_BAD_ENC;
    r.code_point = '0;
    r.bytes_used = used;
    return r;
  endfunction

  // Complete sequence: overlong check, then surrogate / out-of-range check.
  function automatic result_t finish(input logic [20:0] cp, input logic [2:0] len);
    result_t r;
    logic    overlong;
    logic    bad_char;
    overlong = (len == 3'd2 && cp < 21'h80) ||
               (len == 3'd3 && cp < 21'h800) ||
               (len == 3'd4 && cp < 21'h10000);
    bad_char = (cp[20:11] == 10'h01B) || (cp[20:16] > 5'h10);
    r.bytes_used = {5'd0, len};
    if (overlong) begin
      r.status     = ST_BAD_ENC;
      r.code_point = '0;
    end else if (bad_char) begin
      r.status     = ST_BAD_CHAR;
      r.code_point = cp;
    end else begin
      r.status     = ST_VALID;
      r.code_point = cp;
    end
    return r;
  endfunction

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign is_cont   = (data_byte[7:6] == 2'b10);
  assign seen_inc  = (seen == 8'hFF) ? seen : seen + 8'd1;
  assign acc_shift = {acc[14:0], data_byte[5:0]};

  always_comb begin
    rec          = '0;
    mode_next    = mode;
    acc_next     = acc;
    exp_len_next = exp_len;
    seen_next    = seen;
    taken        = 1'b0;

    unique case (mode)
      MODE_COLLECT: begin
        if (is_cont) begin
          taken     = 1'b1;
          acc_next  = acc_shift;
          seen_next = seen_inc;
          if (seen_inc >= {5'd0, exp_len}) begin
            rec.a_valid  = 1'b1;
            rec.a        = finish(acc_shift, exp_len);
            mode_next    = MODE_IDLE;
            acc_next     = '0;
            exp_len_next = '0;
            seen_next    = '0;
          end
        end else begin
          rec.a_valid = 1'b1;
          rec.a       = bad_enc(seen);
        end
      end
      MODE_SKIP: begin
        if (is_cont) begin
          taken     = 1'b1;
          seen_next = seen_inc;
        end else begin
          rec.a_valid = 1'b1;
          rec.a       = bad_enc(seen);
        end
      end
      MODE_IDLE: ;
      default: ;
    endcase

    if (!taken) begin
      // start of a new sequence
      priority if (!data_byte[7]) begin
        rec.b_valid         = 1'b1;
        rec.b.status        = ST_VALID;
        rec.b.code_point    = {13'd0, data_byte};
        rec.b.bytes_used    = 8'd1;
        mode_next           = MODE_IDLE;
        acc_next            = '0;
        exp_len_next        = '0;
        seen_next           = '0;
      end else if (data_byte[7:5] == 3'b110) begin
        mode_next    = MODE_COLLECT;
        acc_next     = {16'd0, data_byte[4:0]};
        exp_len_next = 3'd2;
        seen_next    = 8'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        mode_next    = MODE_COLLECT;
        acc_next     = {17'd0, data_byte[3:0]};
        exp_len_next = 3'd3;
        seen_next    = 8'd1;
      end else if (data_byte[7:3] == 5'b11110) begin
        mode_next    = MODE_COLLECT;
        acc_next     = {18'd0, data_byte[2:0]};
        exp_len_next = 3'd4;
        seen_next    = 8'd1;
      end else begin
        // stray continuation or 0xF8..0xFF: opens a bad run
        mode_next    = MODE_SKIP;
        acc_next     = '0;
        exp_len_next = '0;
        seen_next    = 8'd1;
      end
    end

    // end of buffer flushes whatever is still open
    if (end_of_buffer && mode_next != MODE_IDLE) begin
      rec.b_valid  = 1'b1;
      rec.b        = bad_enc(seen_next);
      mode_next    = MODE_IDLE;
      acc_next     = '0;
      exp_len_next = '0;
      seen_next    = '0;
    end
  end

  assign push     = accept && (rec.a_valid || rec.b_valid);
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      acc     <= '0;
      exp_len <= '0;
      seen    <= '0;
    end else if (accept) begin
      mode    <= mode_next;
      acc     <= acc_next;
      exp_len <= exp_len_next;
      seen    <= seen_next;
    end
  end

  a_collect_len: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_COLLECT |-> (exp_len >= 3'd2 && exp_len <= 3'd4 && seen < {5'd0, exp_len}))
    else $error("collect mode with bad expected length or count");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> (seen == 8'd0 && exp_len == 3'd0))
    else $error("idle mode with stale sequence state");

endmodule

// ===== src/u8d_queue.sv =====
// Short record queue between front and back.
// Depends on u8d_pkg.
module u8d_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  u8d_pkg::record_t push_rec,
  output logic             full,
  input  logic             pop,
  output u8d_pkg::record_t head_rec,
  output logic             empty
);
  import u8d_pkg::*;

  record_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");

endmodule

// ===== src/u8d_back.sv =====
// Back end: drains records from the queue and emits their results one per
// cycle while the output is not stalled, through a registered output stage. Depends on u8d_pkg.
module u8d_back (
  input  logic             clk,
  input  logic             rst,
  input  u8d_pkg::record_t head_rec,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [20:0]      code_point,
  output logic [7:0]       bytes_used,
  output logic             run_final
);
  import u8d_pkg::*;

  logic    a_done;     // first result of head record already sent
  logic    cur_first;
  logic    cur_last;
  logic    load;
  result_t cur;

  assign cur_first = head_rec.a_valid && !a_done;
  assign cur       = cur_first ? head_rec.a : head_rec.b;
  assign cur_last  = !cur_first || !head_rec.b_valid;
  assign load      = !empty && (!out_valid || !out_stall);
  assign pop       = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      a_done    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        a_done    <= !cur_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= cur.status;
      code_point <= cur.code_point;
      bytes_used <= cur.bytes_used;
      run_final  <= cur_last;
    end
  end

  a_second_pending: assert property (@(posedge clk) disable iff (rst)
    a_done |-> (!empty && head_rec.a_valid && head_rec.b_valid))
    else $error("split record lost from queue head");

  a_nonfinal_followed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_final) |-> !empty)
    else $error("non-final result without its follower queued");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for utf8_stream_decoder: directed and random byte streams.
// Depends on u8d_pkg (status codes, result layout) and the decoder RTL.
`timescale 1ns / 100ps

module tb;
  import u8d_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES    = 80;    // long output hold-off used to back up the block
  localparam int DRAIN_CYCLES   = 16;    // settle time after the last result
  localparam int MAX_REPORTS    = 60;

  // Decoder sequence state kept by the predictor.
  typedef enum logic [1:0] {
    SEQ_IDLE    = 2'd0,
    SEQ_COLLECT = 2'd1,
    SEQ_SKIP    = 2'd2
  } seq_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eob;
  } byte_item_t;

  typedef struct packed {
    result_t res;
    logic    fin;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [20:0] code_point;
  logic [7:0]  bytes_used;
  logic        run_final;

  byte_item_t byte_q[$];      // bytes waiting to be offered
  decoded_t   decoded_q[$];   // predicted results, oldest first

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_req        = 0;    // bumped by the stimulus to ask for a long hold-off
  int bytes_added     = 0;
  int mismatch_count  = 0;
  int idle_cycles     = 0;

  // predictor state
  seq_mode_t   seq_mode = SEQ_IDLE;
  logic [20:0] seq_acc  = '0;
  logic [2:0]  seq_len  = '0;
  logic [7:0]  seq_seen = '0;

  always #2 clk = ~clk;

  utf8_stream_decoder u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .code_point    (code_point),
    .bytes_used    (bytes_used),
    .run_final     (run_final)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic result_t mk_result(status_t s, logic [20:0] cp, logic [7:0] used);
    result_t r;
    r.status     = s;
    r.code_point = cp;
    r.bytes_used = used;
    return r;
  endfunction

  task automatic clear_seq();
    seq_mode = SEQ_IDLE;
    seq_acc  = '0;
    seq_len  = '0;
    seq_seen = '0;
  endtask

  // Run one accepted byte through the decoder state and queue what it yields.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    result_t     res [2];
    int          n;
    logic        taken;
    logic        is_cont;
    logic        overlong;
    logic [20:0] cp;
    decoded_t    d;
    n = 0;
    taken = 1'b0;
    is_cont = (b[7:6] == 2'b10);

    case (seq_mode)
      SEQ_COLLECT: begin
        if (is_cont) begin
          seq_acc = {seq_acc[14:0], b[5:0]};
          if (seq_seen != 8'hFF) seq_seen = seq_seen + 8'd1;
          if (seq_seen >= {5'd0, seq_len}) begin
            cp = seq_acc;
            overlong = (seq_len == 3'd2 && cp < 21'h80) ||
                       (seq_len == 3'd3 && cp < 21'h800) ||
                       (seq_len == 3'd4 && cp < 21'h10000);
            if (overlong)
              res[n] = mk_result(ST_BAD_ENC, 21'd0, {5'd0, seq_len});
            else if ((cp >= 21'hD800 && cp <= 21'hDFFF) || cp > 21'h10FFFF)
              res[n] = mk_result(ST_BAD_CHAR, cp, {5'd0, seq_len});
            else
              res[n] = mk_result(ST_VALID, cp, {5'd0, seq_len});
            n++;
            clear_seq();
          end
          taken = 1'b1;
        end else begin
          // truncated: a non-continuation byte cut the sequence short
          res[n] = mk_result(ST_BAD_ENC, 21'd0, seq_seen);
          n++;
          clear_seq();
        end
      end
      SEQ_SKIP: begin
        if (is_cont) begin
          if (seq_seen != 8'hFF) seq_seen = seq_seen + 8'd1;
          taken = 1'b1;
        end else begin
          res[n] = mk_result(ST_BAD_ENC, 21'd0, seq_seen);
          n++;
          clear_seq();
        end
      end
      default: clear_seq();
    endcase

    // byte not absorbed above opens a new sequence
    if (!taken) begin
      if (b[7] == 1'b0) begin
        res[n] = mk_result(ST_VALID, {14'd0, b[6:0]}, 8'd1);
        n++;
      end else if (b[7:5] == 3'b110) begin
        seq_mode = SEQ_COLLECT; seq_acc = {16'd0, b[4:0]}; seq_len = 3'd2; seq_seen = 8'd1;
      end else if (b[7:4] == 4'b1110) begin
        seq_mode = SEQ_COLLECT; seq_acc = {17'd0, b[3:0]}; seq_len = 3'd3; seq_seen = 8'd1;
      end else if (b[7:3] == 5'b11110) begin
        seq_mode = SEQ_COLLECT; seq_acc = {18'd0, b[2:0]}; seq_len = 3'd4; seq_seen = 8'd1;
      end else begin
        // stray continuation or 0xF8..0xFF lead: start a bad run
        seq_mode = SEQ_SKIP; seq_acc = '0; seq_len = '0; seq_seen = 8'd1;
      end
    end

    // end of buffer flushes whatever is still open
    if (last && seq_mode != SEQ_IDLE) begin
      res[n] = mk_result(ST_BAD_ENC, 21'd0, seq_seen);
      n++;
      clear_seq();
    end

    for (int i = 0; i < n; i++) begin
      d.res = res[i];
      d.fin = (i == n - 1);
      decoded_q.push_back(d);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on every accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_p
    byte_item_t nxt;
    logic       take;
    if (rst) begin
      in_valid      <= 1'b0;
      data_byte     <= 8'd0;
      end_of_buffer <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) decode_byte(data_byte, end_of_buffer);
      // payload stays put while stalled; a new byte only after the old one moved
      if (!in_valid || take) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = byte_q.pop_front();
          in_valid      <= 1'b1;
          data_byte     <= nxt.b;
          end_of_buffer <= nxt.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report(input string field, input int exp_v, input int got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
  endtask

  always @(posedge clk) begin : check_p
    decoded_t d;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got status %0d cp 0x%0h used %0d",
                   $time, status, code_point, bytes_used);
      end else begin
        d = decoded_q.pop_front();
        if (d.res.status !== status)
          report("status", int'(d.res.status), int'(status));
        if (d.res.code_point !== code_point)
          report("code_point", int'(d.res.code_point), int'(code_point));
        if (d.res.bytes_used !== bytes_used)
          report("bytes_used", int'(d.res.bytes_used), int'(bytes_used));
        if (d.fin !== run_final)
          report("run_final", int'(d.fin), int'(run_final));
      end
    end
  end

  // Watchdog: nothing moving on either side for too long ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eob);
    byte_item_t it;
    it.b   = b;
    it.eob = eob;
    byte_q.push_back(it);
    bytes_added++;
  endtask

  // Encode cp in len bytes (longer than needed gives an overlong form), keep the
  // first keep bytes; eob goes on the last byte kept.
  task automatic put_seq(input logic [20:0] cp, input int len, input int keep,
                         input logic eob);
    logic [7:0] enc [4];
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) push_byte(enc[i], eob && (i == keep - 1));
  endtask

  // Mostly well-formed characters with random content, the rest broken
  // sequences and noise.
  task automatic add_random_unit();
    int          r;
    int          len;
    int          run;
    logic        eob;
    logic [20:0] lim;
    r   = $urandom_range(99);
    eob = ($urandom_range(15) == 0);
    if (r < 15) begin
      put_seq(21'($urandom_range(127)), 1, 1, eob);
    end else if (r < 30) begin
      put_seq(21'($urandom_range(21'h7FF, 21'h80)), 2, 2, eob);
    end else if (r < 45) begin
      put_seq(21'($urandom_range(21'hFFFF, 21'h800)), 3, 3, eob);
    end else if (r < 58) begin
      put_seq(21'($urandom_range(21'h10FFFF, 21'h10000)), 4, 4, eob);
    end else if (r < 64) begin
      // beyond the last scalar, includes leads 0xF5..0xF7
      put_seq(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4, 4, eob);
    end else if (r < 68) begin
      put_seq(21'($urandom_range(21'hDFFF, 21'hD800)), 3, 3, eob);
    end else if (r < 76) begin
      len = $urandom_range(4, 2);
      lim = (len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF;
      put_seq(21'($urandom_range(lim, 0)), len, len, eob);
    end else if (r < 86) begin
      // truncated: closed by whatever comes next, or flushed by end of buffer
      len = $urandom_range(4, 2);
      put_seq(21'($urandom_range(21'h1FFFFF)), len, $urandom_range(len - 1, 1),
              1'($urandom_range(1)));
    end else begin
      run = $urandom_range(4);
      case ($urandom_range(3))
        0: push_byte(8'($urandom_range(255)), eob);
        1: push_byte(8'($urandom_range(8'hBF, 8'h80)), eob && run == 0);
        2: push_byte(8'($urandom_range(8'hFF, 8'hF8)), eob && run == 0);
        default: begin
          // lead byte followed by anything at all
          push_byte(8'($urandom_range(8'hFF, 8'hC0)), 1'b0);
          push_byte(8'($urandom_range(255)), eob);
          run = 0;
        end
      endcase
      for (int i = 0; i < run; i++)
        push_byte({2'b10, 6'($urandom_range(63))}, eob && (i == run - 1));
    end
  endtask

  task automatic add_random(input int count);
    int start;
    start = bytes_added;
    while (bytes_added - start < count) add_random_unit();
  endtask

  // Everything offered has moved and every predicted result has come out.
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes and each special case, no idling.
    push_byte(8'h00, 1'b0);                       // lowest ASCII
    push_byte(8'h7F, 1'b0);                       // highest ASCII
    put_seq(21'h80, 2, 2, 1'b0);                  // smallest two-byte
    put_seq(21'h10FFFF, 4, 4, 1'b0);              // largest scalar
    put_seq(21'h7F, 2, 2, 1'b0);                  // overlong two-byte
    put_seq(21'hD800, 3, 3, 1'b0);                // surrogate
    put_seq(21'h140000, 4, 4, 1'b0);              // above range, lead 0xF5
    push_byte(8'h80, 1'b0);                       // stray continuation run
    push_byte(8'hBF, 1'b0);
    push_byte(8'hFF, 1'b0);                       // invalid lead, closed by ASCII
    push_byte(8'h41, 1'b0);
    put_seq(21'h20AC, 3, 2, 1'b0);                // truncated by ASCII
    push_byte(8'h41, 1'b0);
    push_byte(8'hF0, 1'b1);                       // open lead flushed by end of buffer
    wait_drained();

    sender_idle_pct = 0;  recv_stall_pct = 0;  add_random(300); wait_drained();
    sender_idle_pct = 59; recv_stall_pct = 0;  add_random(300); wait_drained();
    sender_idle_pct = 0;  recv_stall_pct = 59; add_random(300); wait_drained();
    sender_idle_pct = 14; recv_stall_pct = 14; add_random(300); wait_drained();

    // Output held off for a long stretch while bytes keep coming: the record
    // queue fills and the input has to stall.
    sender_idle_pct = 0;  recv_stall_pct = 0;
    hold_req = hold_req + 1;
    add_random(150);
    wait_drained();

    // Bad run long enough to saturate the byte count.
    sender_idle_pct = 14; recv_stall_pct = 14;
    push_byte(8'($urandom_range(8'hFF, 8'hF8)), 1'b0);
    for (int i = 0; i < 290; i++) push_byte({2'b10, 6'($urandom_range(63))}, i == 289);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && decoded_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
